[sv/cell_write_dirty_range_tracker_macros.svh]
// Assertion macros for the dirty range tracker.
`ifndef CELL_WRITE_DIRTY_RANGE_TRACKER_MACROS_SVH
`define CELL_WRITE_DIRTY_RANGE_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CWDRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwdrt assertion failed");

// next-cycle implication
`define CWDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwdrt assertion failed");

`else

`define CWDRT_ASSERT_NOW(label, clk, rst, ante, cons)
`define CWDRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/cwdrt_pkg.sv]
package cwdrt_pkg;

  localparam int unsigned SPACE_CODE = 32'h20;

  typedef enum logic [0:0] {
    CFG_COLS_IN_USE   = 1'b0,
    CFG_TRACK_UPDATES = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  pos_x;
    logic [5:0]  pos_y;
    logic [20:0] char_code;
    logic [1:0]  action_kind;
  } in_word_t;

  typedef struct packed {
    logic       cell_changed;
    logic       range_merged;
    logic       range_opened;
    logic [7:0] top_start_x;
    logic [5:0] top_start_y;
    logic [7:0] top_end_x;
    logic [5:0] top_end_y;
    logic [7:0] top_left_bound;
    logic [7:0] top_right_bound;
    logic [1:0] top_action;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] start_x;
    logic [5:0] start_y;
    logic [7:0] end_x;
    logic [5:0] end_y;
    logic [7:0] left;
    logic [7:0] right;
    logic [1:0] action;
  } range_t;

endpackage

[sv/cwdrt_stream_if.sv]
interface cwdrt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/cell_write_dirty_range_tracker.sv]
// Character cell store with dirty-range coalescing.
//
// req (sink) carries one write word: column, line, character code and an
// action tag. rsp (source) returns one word per write: changed / merged /
// opened flags and the top dirty range after that write. Both channels use
// valid/ready; a word moves when both are high.
// cfg_we/cfg_index/cfg_data write the screen width and the tracking enable.
//
// Each word passes a cell read, then compare, range update and write-back
// into the rsp register. Throughput: one word per cycle when rsp does not
// stall and clearing is done; cells are read at accept and written as the
// word leaves compare, and a write to the cell the next word reads is forwarded.
// A stalled rsp holds its word; one more word can sit in the compare stage,
// after which req.ready drops.
// Reset: range registers clear, width returns to 80, tracking on. Then a
// clearing pass fills every cell with a space, one cell per cycle, with
// req.ready low. Config writes are taken.
`include "cell_write_dirty_range_tracker_macros.svh"

module cell_write_dirty_range_tracker
  import cwdrt_pkg::*;
#(
  parameter int MAX_LINES = 64,
  parameter int MAX_COLS  = 256,
  parameter int CHAR_BITS = 21
) (
  input  logic                   clk,
  input  logic                   rst,
  cwdrt_stream_if.sink           req,
  cwdrt_stream_if.source         rsp,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [8:0]             cfg_data
);

  localparam int DEPTH = MAX_LINES * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [8:0] cols_in_use;
  logic       track_updates;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use   <= 9'd80;
      track_updates <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS_IN_USE:   cols_in_use   <= cfg_data;
        CFG_TRACK_UPDATES: track_updates <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // stage 1 control and payload
  logic                 s1_valid;
  logic                 s1_inb;
  logic [AW-1:0]        s1_addr;
  logic [CHAR_BITS-1:0] s1_code;
  in_word_t             s1_word;

  logic                 out_valid;
  out_word_t            out_data;

  logic                 accept;
  logic                 adv;
  logic                 in_bounds;
  logic [AW-1:0]        raddr;
  logic [CHAR_BITS-1:0] in_code;

  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || adv);
  assign accept    = req.valid && req.ready;

  assign in_bounds = (32'(req.data.pos_x) < 32'(MAX_COLS)) &&
                     (32'(req.data.pos_y) < 32'(MAX_LINES));
  assign raddr     = AW'(32'(req.data.pos_y) * 32'(MAX_COLS) + 32'(req.data.pos_x));
  assign in_code   = CHAR_BITS'(req.data.char_code);

  // cell memory
  logic [CHAR_BITS-1:0] mem [DEPTH];
  logic [CHAR_BITS-1:0] rd_data;
  logic                 fwd;
  logic [CHAR_BITS-1:0] fwd_data;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CHAR_BITS-1:0] mem_wdata;
  logic [CHAR_BITS-1:0] cur_code;
  logic                 changed;

  assign cur_code  = fwd ? fwd_data : rd_data;
  assign changed   = s1_inb && (cur_code != s1_code);
  assign mem_we    = clearing || (adv && changed);
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? CHAR_BITS'(SPACE_CODE) : s1_code;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= mem[raddr];
    end
  end

  // the read above sees the old cell when stage 1 writes the same one
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= adv && changed && (raddr == s1_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= s1_code;
      s1_inb   <= in_bounds;
      s1_addr  <= raddr;
      s1_code  <= in_code;
      s1_word  <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // dirty range
  range_t range_q;
  range_t range_next;
  logic   single_row;
  logic   cont_row;
  logic   next_row;
  logic   merge_ok;
  logic   merged;
  logic   opened;

  always_comb begin
    single_row = range_q.start_y == range_q.end_y;
    cont_row   = (range_q.end_y == s1_word.pos_y) &&
                 (({1'b0, range_q.end_x} + 9'd1) == {1'b0, s1_word.pos_x});
    next_row   = ({1'b0, range_q.end_y} + 7'd1) == {1'b0, s1_word.pos_y};
    merge_ok   = range_q.valid &&
                 ((single_row && (cont_row || (next_row && s1_word.pos_x <= range_q.start_x))) ||
                  (cont_row && s1_word.pos_x <= range_q.right) ||
                  (next_row && s1_word.pos_x == range_q.left));
    merged     = changed && track_updates && merge_ok;
    opened     = changed && track_updates && !merge_ok;

    range_next = range_q;
    if (merged) begin
      if (single_row && next_row) begin
        range_next.left  = s1_word.pos_x;
        range_next.right = range_q.end_x;
      end
      range_next.end_x = s1_word.pos_x;
      range_next.end_y = s1_word.pos_y;
    end else if (opened) begin
      range_next.valid   = 1'b1;
      range_next.action  = s1_word.action_kind;
      range_next.left    = 8'd0;
      range_next.right   = 8'(cols_in_use - 9'd1);
      range_next.start_x = s1_word.pos_x;
      range_next.start_y = s1_word.pos_y;
      range_next.end_x   = s1_word.pos_x;
      range_next.end_y   = s1_word.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_q <= '0;
    end else if (adv) begin
      range_q <= range_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.cell_changed    <= changed;
      out_data.range_merged    <= merged;
      out_data.range_opened    <= opened;
      out_data.top_start_x     <= range_next.start_x;
      out_data.top_start_y     <= range_next.start_y;
      out_data.top_end_x       <= range_next.end_x;
      out_data.top_end_y       <= range_next.end_y;
      out_data.top_left_bound  <= range_next.left;
      out_data.top_right_bound <= range_next.right;
      out_data.top_action      <= range_next.action;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // checks
  `CWDRT_ASSERT_NOW(a_flags_need_change, clk, rst,
    out_valid && (out_data.range_merged || out_data.range_opened), out_data.cell_changed)
  `CWDRT_ASSERT_NOW(a_merge_open_excl, clk, rst,
    out_valid, !(out_data.range_merged && out_data.range_opened))
  `CWDRT_ASSERT_NEXT(a_merge_keeps_start, clk, rst,
    adv && merged, $stable(range_q.start_x) && $stable(range_q.start_y))
  `CWDRT_ASSERT_NEXT(a_forward_taken, clk, rst,
    accept && adv && changed && (raddr == s1_addr), fwd)

endmodule
